[hdl/iafp_pkg.sv]
package iafp_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned ANGLE_W     = 17;
  localparam int unsigned PAYLOAD_LEN = 9;
  localparam int unsigned DATA_LEN    = PAYLOAD_LEN - 1;
  localparam int unsigned ANGLE_BYTES = 6;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned IDX_W       = $clog2(ANGLE_BYTES);

  typedef logic [BYTE_W-1:0]         byte_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic [CNT_W-1:0]          cnt_t;

  localparam byte_t HDR_FIRST  = 8'h55;
  localparam byte_t HDR_SECOND = 8'h53;
  localparam byte_t CKSUM_INIT = HDR_FIRST + HDR_SECOND;
  localparam cnt_t  DATA_LAST  = cnt_t'(DATA_LEN);
  localparam logic [2*BYTE_W-1:0] HALF_TURN = 16'h8000;

  // raw words above a half turn wrap to negative
  function automatic angle_t to_angle(input byte_t lo, input byte_t hi);
    logic [2*BYTE_W-1:0] raw;
    raw = {hi, lo};
    return angle_t'({(raw > HALF_TURN), raw});
  endfunction

endpackage

[hdl/iafp_if.sv]
interface iafp_byte_if;
  logic          valid;
  logic          ready;
  iafp_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface iafp_angle_if;
  logic             valid;
  logic             ready;
  iafp_pkg::angle_t roll_angle;
  iafp_pkg::angle_t pitch_angle;
  iafp_pkg::angle_t yaw_angle;

  modport source (output valid, output roll_angle, output pitch_angle, output yaw_angle,
                  input ready);
  modport sink   (input valid, input roll_angle, input pitch_angle, input yaw_angle,
                  output ready);
endinterface

[hdl/imu_angle_frame_parser_core.sv]
// Path: a byte is registered in the input register on acceptance and parsed there; the
//   frame's checksum beat, if its sum is good, loads the result register as a result beat.
// Throughput: one byte per cycle; only a checksum beat with a good sum waits on a
//   stalled result register, every other byte flows past it.
// Reset: rst_n synchronous, active low; clears the parser to header hunting and
//   empties the input and result registers. Payload registers are not reset.
module imu_angle_frame_parser_core (
  input  logic                clk,
  input  logic                rst_n,
  iafp_byte_if.sink           in_if,
  iafp_angle_if.source        out_if
);
  import iafp_pkg::*;

  typedef enum logic [1:0] {
    PH_HDR1,
    PH_HDR2,
    PH_DATA
  } phase_t;

  phase_t phase_r, phase_nxt;
  cnt_t   cnt_r, cnt_nxt;
  byte_t  sum_r, sum_nxt;
  byte_t  pay_r [ANGLE_BYTES];

  logic   s1_valid_r, s1_valid_nxt;
  byte_t  s1_byte_r;

  logic   out_valid_r, out_valid_nxt;
  angle_t roll_r, pitch_r, yaw_r;

  logic   in_fire, s1_fire, s1_go, is_end, produces, out_free, out_load, pay_wr;

  assign in_fire  = in_if.valid && in_if.ready;
  assign is_end   = (phase_r == PH_DATA) && (cnt_r == DATA_LAST);
  assign produces = s1_valid_r && is_end && (sum_r == s1_byte_r);
  assign out_free = !out_valid_r || out_if.ready;
  assign s1_go    = !produces || out_free;
  assign s1_fire  = s1_valid_r && s1_go;
  assign out_load = produces && out_free;
  assign pay_wr   = s1_fire && (phase_r == PH_DATA) && (cnt_r < cnt_t'(ANGLE_BYTES));

  assign in_if.ready        = !s1_valid_r || s1_go;
  assign out_if.valid       = out_valid_r;
  assign out_if.roll_angle  = roll_r;
  assign out_if.pitch_angle = pitch_r;
  assign out_if.yaw_angle   = yaw_r;

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;

    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (s1_fire) begin
      case (phase_r)
        PH_HDR2: begin
          if (s1_byte_r == HDR_SECOND) begin
            phase_nxt = PH_DATA;
            cnt_nxt   = '0;
            sum_nxt   = CKSUM_INIT;
          end else begin
            phase_nxt = PH_HDR1;
          end
        end
        PH_DATA: begin
          if (cnt_r < DATA_LAST) begin
            cnt_nxt = cnt_r + cnt_t'(1);
            sum_nxt = sum_r + s1_byte_r;
          end else begin
            cnt_nxt   = '0;
            phase_nxt = PH_HDR1;
          end
        end
        default: begin
          phase_nxt = (s1_byte_r == HDR_FIRST) ? PH_HDR2 : PH_HDR1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR1;
      cnt_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sum_r <= sum_nxt;
    if (in_fire) begin
      s1_byte_r <= in_if.rx_byte;
    end
    if (pay_wr) begin
      pay_r[cnt_r[IDX_W-1:0]] <= s1_byte_r;
    end
    if (out_load) begin
      roll_r  <= to_angle(pay_r[0], pay_r[1]);
      pitch_r <= to_angle(pay_r[2], pay_r[3]);
      yaw_r   <= to_angle(pay_r[4], pay_r[5]);
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DATA_LAST)
    else $error("payload count beyond frame length");

  a_stall_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (s1_valid_r && is_end && out_valid_r))
    else $error("input stalled without a pending result beat");

  a_frame_end_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && is_end) |=> (phase_r == PH_HDR1 && cnt_r == '0))
    else $error("parser did not return to header hunt after checksum");

  a_result_from_checksum: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (s1_valid_r && phase_r == PH_DATA && sum_r == s1_byte_r))
    else $error("result loaded outside a good checksum beat");

endmodule

[test/imu_angle_frame_parser_core_tb.sv]
`timescale 1ns / 1ps

module imu_angle_frame_parser_core_tb;
  import iafp_pkg::*;

  localparam int unsigned BYTE_COUNT  = 1800;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned TAIL_CYCLES = 12;

  typedef enum logic [1:0] {HUNT_FIRST, HUNT_SECOND, TAKE_PAYLOAD} hunt_phase_t;
  typedef enum logic [1:0] {FROM_MODEL, NO_RESULT, TYPED} outcome_t;

  typedef struct packed {
    angle_t roll;
    angle_t pitch;
    angle_t yaw;
  } attitude_t;

  typedef struct packed {
    logic [1:0]  n_lead;
    logic [15:0] lead;
    byte_t       hdr2;
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic [15:0] ver;
    byte_t       sum_err;
    outcome_t    outcome;
    attitude_t   typed;
  } frame_row_t;

  localparam frame_row_t DIRECTED [6] = '{
    '{2'd0, 16'h0000, HDR_SECOND, 16'h0000, 16'h8000, 16'h8001, 16'h0000, 8'h00, TYPED,
      '{17'sd0, 17'sd32768, -17'sd32767}},
    '{2'd0, 16'h0000, HDR_SECOND, 16'hFFFF, 16'h7FFF, 16'h0001, 16'hFFFF, 8'h00, TYPED,
      '{-17'sd1, 17'sd32767, 17'sd1}},
    '{2'd0, 16'h0000, HDR_SECOND, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 8'h80, NO_RESULT,
      '0},
    '{2'd0, 16'h0000, 8'h52, 16'h0102, 16'h0000, 16'h0000, 16'h0000, 8'h00, NO_RESULT, '0},
    '{2'd1, 16'h0055, HDR_SECOND, 16'h1234, 16'h0000, 16'h0000, 16'h0000, 8'h00, NO_RESULT,
      '0},
    '{2'd2, 16'hFF00, HDR_SECOND, 16'hC000, 16'h4000, 16'h8000, 16'h1357, 8'h00, FROM_MODEL,
      '0}
  };

  logic clk;
  logic rst_n;

  iafp_byte_if  in_ch ();
  iafp_angle_if out_ch ();

  imu_angle_frame_parser_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  hunt_phase_t phase;
  cnt_t        taken;
  byte_t       frame_bytes [DATA_LEN];
  attitude_t   pending_attitudes [$];
  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned quiet_cycles;
  int unsigned send_calm;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic angle_t word_to_angle(input byte_t lo, input byte_t hi);
    int v;
    v = int'({hi, lo});
    if (v > 32768) v = v - 65536;
    return angle_t'(v);
  endfunction

  // parser state tracking; returns 1 when a frame with a good sum completes
  function automatic bit parse_byte(input byte_t b, output attitude_t att);
    byte_t sum;
    att = '0;
    parse_byte = 1'b0;
    case (phase)
      HUNT_SECOND: begin
        phase = (b == HDR_SECOND) ? TAKE_PAYLOAD : HUNT_FIRST;
        taken = '0;
      end
      TAKE_PAYLOAD: begin
        if (taken < DATA_LAST) begin
          frame_bytes[taken] = b;
          taken = taken + 1'b1;
        end else begin
          sum = CKSUM_INIT;
          foreach (frame_bytes[i]) sum = sum + frame_bytes[i];
          if (sum == b) begin
            att.roll  = word_to_angle(frame_bytes[0], frame_bytes[1]);
            att.pitch = word_to_angle(frame_bytes[2], frame_bytes[3]);
            att.yaw   = word_to_angle(frame_bytes[4], frame_bytes[5]);
            parse_byte = 1'b1;
          end
          taken = '0;
          phase = HUNT_FIRST;
        end
      end
      default: phase = (b == HDR_FIRST) ? HUNT_SECOND : HUNT_FIRST;
    endcase
  endfunction

  task automatic send_byte(input byte_t b, input outcome_t outcome, input attitude_t typed);
    attitude_t   predicted;
    bit          got;
    int unsigned gap;
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    got = parse_byte(b, predicted);
    case (outcome)
      FROM_MODEL: if (got) pending_attitudes.push_back(predicted);
      TYPED:      pending_attitudes.push_back(typed);
      default:    ;
    endcase
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 49) == 0) send_calm = 40;
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input frame_row_t r);
    byte_t body [DATA_LEN];
    byte_t sum;
    body = '{r.roll[7:0], r.roll[15:8], r.pitch[7:0], r.pitch[15:8],
             r.yaw[7:0], r.yaw[15:8], r.ver[7:0], r.ver[15:8]};
    sum = CKSUM_INIT;
    foreach (body[i]) sum = sum + body[i];
    if (r.n_lead > 0) send_byte(r.lead[7:0], FROM_MODEL, '0);
    if (r.n_lead > 1) send_byte(r.lead[15:8], FROM_MODEL, '0);
    send_byte(HDR_FIRST, FROM_MODEL, '0);
    send_byte(r.hdr2, FROM_MODEL, '0);
    foreach (body[i]) send_byte(body[i], FROM_MODEL, '0);
    send_byte(byte_t'(sum + r.sum_err), r.outcome, r.typed);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'h7FFF;
      2:       return 16'h8000;
      3:       return 16'h8001;
      4:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_traffic();
    frame_row_t  r;
    int unsigned pick;
    int unsigned n;
    while (bytes_sent < BYTE_COUNT) begin
      pick      = $urandom_range(0, 99);
      r         = '0;
      r.hdr2    = HDR_SECOND;
      r.roll    = pick_word();
      r.pitch   = pick_word();
      r.yaw     = pick_word();
      r.ver     = 16'($urandom);
      r.outcome = FROM_MODEL;
      if ($urandom_range(0, 3) == 0) begin
        r.n_lead = 2'($urandom_range(1, 2));
        r.lead   = 16'($urandom);
      end
      if (pick < 70) begin
        send_frame(r);
      end else if (pick < 82) begin
        r.sum_err = byte_t'($urandom_range(1, 255));
        send_frame(r);
      end else if (pick < 90) begin
        do r.hdr2 = byte_t'($urandom); while (r.hdr2 == HDR_SECOND);
        send_frame(r);
      end else if (pick < 95) begin
        r.n_lead = 2'd1;
        r.lead   = {8'h00, HDR_FIRST};
        send_frame(r);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(($urandom_range(0, 2) == 0) ? HDR_FIRST : byte_t'($urandom),
                             FROM_MODEL, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    attitude_t exp_att;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_attitudes.size() == 0) begin
        $display("%0t unexpected beat: roll %0d pitch %0d yaw %0d", $time,
                 out_ch.roll_angle, out_ch.pitch_angle, out_ch.yaw_angle);
        mismatches++;
      end else begin
        exp_att = pending_attitudes.pop_front();
        if (out_ch.roll_angle !== exp_att.roll) begin
          $display("%0t roll expected %0d actual %0d", $time, exp_att.roll,
                   out_ch.roll_angle);
          mismatches++;
        end
        if (out_ch.pitch_angle !== exp_att.pitch) begin
          $display("%0t pitch expected %0d actual %0d", $time, exp_att.pitch,
                   out_ch.pitch_angle);
          mismatches++;
        end
        if (out_ch.yaw_angle !== exp_att.yaw) begin
          $display("%0t yaw expected %0d actual %0d", $time, exp_att.yaw,
                   out_ch.yaw_angle);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random back-pressure, two long holds to fill the block
  initial begin : result_sink
    int unsigned stall;
    int unsigned beats;
    int unsigned calm;
    beats = 0;
    calm  = 0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (beats == 12 || beats == 90) begin
        stall = LONG_HOLD;
      end else if (calm > 0) begin
        calm--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 11);
        if ($urandom_range(0, 19) == 0) calm = 25;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      beats++;
    end
  end

  initial begin
    phase         = HUNT_FIRST;
    taken         = '0;
    frame_bytes   = '{default: '0};
    mismatches    = 0;
    bytes_sent    = 0;
    quiet_cycles  = 0;
    send_calm     = 0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_frame(DIRECTED[i]);
    send_random_traffic();
    in_ch.valid <= 1'b0;

    while (pending_attitudes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/iafp_pkg.sv
hdl/iafp_if.sv
hdl/imu_angle_frame_parser_core.sv
test/imu_angle_frame_parser_core_tb.sv
